// ===== rtl/pdol_pkg.sv =====
// Package for the PPS disciplined oscillator loop: payload structs, register
// indexes, status codes, widths and reset values. Depends on nothing else.
package pdol_pkg;

  localparam int CAP_W      = 32;
  localparam int SYS_W      = 64;
  localparam int UNIX_W     = 34;
  localparam int STATUS_W   = 2;
  localparam int MEAN_W     = 48;
  localparam int DRIVE_W    = 14;
  localparam int FRAC_W     = 16;
  localparam int DRIVE_Q_W  = DRIVE_W + FRAC_W;
  localparam int TARGET_W   = 31;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 31;
  localparam int SKIP_W     = 8;
  localparam int ERR_W      = 22;
  localparam int ERR_CALC_W = 34;
  localparam int OFF_PROD_W = 55;

  localparam int DEF_WINDOW_DEPTH = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q16      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_START   = 3'd6;

  localparam logic [STATUS_W-1:0] ST_SENTINEL = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STARTUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTLIER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd3;

  localparam logic [CAP_W-1:0]    CAPTURE_SENTINEL = 32'hFFFF_FFFE;
  localparam logic [TARGET_W-1:0] RST_TARGET_COUNT = 31'd62500000;
  localparam logic [GAIN_W-1:0]   RST_GAIN_Q16     = 16'd6554;
  localparam logic [DRIVE_W-1:0]  RST_DRIVE_MAX    = 14'd8192;
  localparam logic [DRIVE_W-1:0]  RST_DRIVE_MIN    = 14'd0;
  localparam logic [LIMIT_W-1:0]  RST_OUTLIER_LIM  = 31'd1000000;
  localparam logic [SKIP_W-1:0]   RST_SKIP_COUNT   = 8'd2;
  localparam logic [DRIVE_W-1:0]  RST_DRIVE_START  = 14'd3846;

  localparam logic signed [ERR_CALC_W-1:0] ERR_SAT_MAX = 34'sd2097151;
  localparam logic signed [ERR_CALC_W-1:0] ERR_SAT_MIN = -34'sd2097152;

  localparam logic [OFF_PROD_W-1:0] US_PER_S = 55'd1000000;

  typedef struct packed {
    logic [CAP_W-1:0]  capture_value;
    logic [SYS_W-1:0]  sysclock_us;
    logic              gps_valid;
    logic [UNIX_W-1:0] gps_unix_seconds;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [CAP_W-1:0]         period_count;
    logic signed [MEAN_W-1:0] mean_error_q16;
    logic [DRIVE_W-1:0]       drive_level;
    logic                     pps_led;
    logic                     offset_valid;
    logic [SYS_W-1:0]         clock_offset_us;
  } out_t;

endpackage

// ===== rtl/pps_disciplined_oscillator_loop_unit.sv =====
// PPS disciplined oscillator loop: top level; uses pdol_pkg, pdol_ram, pdol_div.
// A sentinel or startup transaction goes from evaluation straight to the result step,
// an outlier through the check step; a loop update also reads and sums the filled
// window entries, runs the two bit per cycle divider, then the gain multiply and drive
// update. One transaction at a time; in_ready is high only when idle, in the cycle
// after the result is loaded. Synchronous active-low reset loads the defaults.
module pps_disciplined_oscillator_loop_unit #(
  parameter int WINDOW_DEPTH = pdol_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pdol_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pdol_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pdol_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdol_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = pdol_pkg::ERR_W + $clog2(WINDOW_DEPTH);
  localparam int DVD_W  = SUM_W + pdol_pkg::FRAC_W;
  localparam int PROD_W = DVD_W + pdol_pkg::GAIN_W;
  localparam int DC_W   = DVD_W + 2;
  localparam int FW     = pdol_pkg::FRAC_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_DIVGO = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_DRV   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;

  // Configuration registers.
  logic [pdol_pkg::TARGET_W-1:0] target_r;
  logic [pdol_pkg::GAIN_W-1:0]   gain_r;
  logic [pdol_pkg::DRIVE_W-1:0]  dmax_r;
  logic [pdol_pkg::DRIVE_W-1:0]  dmin_r;
  logic [pdol_pkg::LIMIT_W-1:0]  olim_r;
  logic [pdol_pkg::SKIP_W-1:0]   skip_r;

  // Loop state.
  logic [pdol_pkg::CAP_W-1:0]     last_r;
  logic [pdol_pkg::SKIP_W-1:0]    seen_r;
  logic [AW-1:0]                  wslot_r;
  logic [CNT_W-1:0]               filled_r;
  logic [pdol_pkg::DRIVE_Q_W-1:0] drive_r;
  logic                           led_r;
  logic [pdol_pkg::SYS_W-1:0]     offset_r;
  logic                           out_valid_r;

  // Per-transaction work registers.
  pdol_pkg::in_t                          in_r;
  pdol_pkg::out_t                         out_r;
  logic [pdol_pkg::STATUS_W-1:0]          status_r;
  logic [pdol_pkg::CAP_W-1:0]             period_r;
  logic signed [pdol_pkg::ERR_CALC_W-1:0] err_r;
  logic [pdol_pkg::OFF_PROD_W-1:0]        off_prod_r;
  logic [CNT_W-1:0]                       idx_r;
  logic                                   rd_pend_r;
  logic signed [SUM_W-1:0]                sum_r;
  logic                                   sum_neg_r;
  logic signed [pdol_pkg::MEAN_W-1:0]     mean_r;
  logic [DVD_W-1:0]                       mag_r;
  logic [PROD_W-1:0]                      prod_r;
  logic                                   offv_r;

  logic                                   in_acc;
  logic                                   cfg_acc;
  logic                                   out_load;
  logic                                   is_outlier;
  logic signed [pdol_pkg::ERR_CALC_W-1:0] lim_s;
  logic signed [pdol_pkg::ERR_CALC_W-1:0] err_sat;
  logic [pdol_pkg::CAP_W-1:0]             period_c;
  logic                                   rd_issue;
  logic                                   win_we;
  logic [pdol_pkg::ERR_W-1:0]             win_rdata;
  logic [SUM_W-1:0]                       sum_abs;
  logic                                   div_start;
  logic                                   div_done;
  logic [DVD_W-1:0]                       div_q;
  logic [DVD_W-1:0]                       delta;
  logic signed [DC_W-1:0]                 drv_cur, drv_delta, drv_sum;
  logic signed [DC_W-1:0]                 drv_hi, drv_lo, drv_clamped;

  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign period_c   = last_r - in_r.capture_value;
  assign lim_s      = $signed(pdol_pkg::ERR_CALC_W'(olim_r));
  assign is_outlier = (err_r > lim_s) || (err_r < -lim_s);

  always_comb begin
    if (err_r > pdol_pkg::ERR_SAT_MAX) begin
      err_sat = pdol_pkg::ERR_SAT_MAX;
    end else if (err_r < pdol_pkg::ERR_SAT_MIN) begin
      err_sat = pdol_pkg::ERR_SAT_MIN;
    end else begin
      err_sat = err_r;
    end
  end

  assign win_we   = (state_r == S_CHECK) && !is_outlier;
  assign rd_issue = (state_r == S_SUM) && (idx_r < filled_r);

  pdol_ram #(
    .WIDTH (pdol_pkg::ERR_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (win_we),
    .waddr (wslot_r),
    .wdata (err_sat[pdol_pkg::ERR_W-1:0]),
    .raddr (idx_r[AW-1:0]),
    .rdata (win_rdata)
  );

  assign sum_abs   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign div_start = (state_r == S_DIVGO);

  pdol_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_abs, {FW{1'b0}}}),
    .divisor  (filled_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // The gain product is taken on the magnitude, so dropping the fraction
  // truncates toward zero; the sign of the mean picks add or subtract.
  assign delta     = prod_r[PROD_W-1:FW];
  assign drv_cur   = $signed(DC_W'(drive_r));
  assign drv_delta = $signed(DC_W'(delta));
  assign drv_sum   = sum_neg_r ? (drv_cur + drv_delta) : (drv_cur - drv_delta);
  assign drv_hi    = $signed(DC_W'({dmax_r, {FW{1'b0}}}));
  assign drv_lo    = $signed(DC_W'({dmin_r, {FW{1'b0}}}));

  always_comb begin
    if (drv_sum > drv_hi) begin
      drv_clamped = drv_hi;
    end else if (drv_sum < drv_lo) begin
      drv_clamped = drv_lo;
    end else begin
      drv_clamped = drv_sum;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (in_r.capture_value == pdol_pkg::CAPTURE_SENTINEL || seen_r < skip_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = is_outlier ? S_DONE : S_SUM;
      end
      S_SUM: begin
        if (!rd_issue && !rd_pend_r) begin
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_DRV;
      S_DRV:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and loop state, with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      target_r    <= pdol_pkg::RST_TARGET_COUNT;
      gain_r      <= pdol_pkg::RST_GAIN_Q16;
      dmax_r      <= pdol_pkg::RST_DRIVE_MAX;
      dmin_r      <= pdol_pkg::RST_DRIVE_MIN;
      olim_r      <= pdol_pkg::RST_OUTLIER_LIM;
      skip_r      <= pdol_pkg::RST_SKIP_COUNT;
      last_r      <= '0;
      seen_r      <= '0;
      wslot_r     <= '0;
      filled_r    <= '0;
      drive_r     <= {pdol_pkg::RST_DRIVE_START, {FW{1'b0}}};
      led_r       <= 1'b0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == S_EVAL && in_r.capture_value != pdol_pkg::CAPTURE_SENTINEL) begin
        last_r <= in_r.capture_value;
        if (seen_r < skip_r) begin
          seen_r <= seen_r + 1'b1;
        end else begin
          led_r <= ~led_r;
        end
      end

      if (win_we) begin
        wslot_r <= (wslot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wslot_r + 1'b1;
        if (filled_r != CNT_W'(WINDOW_DEPTH)) begin
          filled_r <= filled_r + 1'b1;
        end
      end

      if (state_r == S_DRV) begin
        drive_r <= drv_clamped[pdol_pkg::DRIVE_Q_W-1:0];
        if (in_r.gps_valid) begin
          offset_r <= pdol_pkg::SYS_W'(off_prod_r) - in_r.sysclock_us;
        end
      end

      if (cfg_acc) begin
        unique case (cfg_index)
          pdol_pkg::CFG_TARGET_COUNT:  target_r <= cfg_data[pdol_pkg::TARGET_W-1:0];
          pdol_pkg::CFG_GAIN_Q16:      gain_r   <= cfg_data[pdol_pkg::GAIN_W-1:0];
          pdol_pkg::CFG_DRIVE_MAX:     dmax_r   <= cfg_data[pdol_pkg::DRIVE_W-1:0];
          pdol_pkg::CFG_DRIVE_MIN:     dmin_r   <= cfg_data[pdol_pkg::DRIVE_W-1:0];
          pdol_pkg::CFG_OUTLIER_LIMIT: olim_r   <= cfg_data[pdol_pkg::LIMIT_W-1:0];
          pdol_pkg::CFG_SKIP_COUNT:    skip_r   <= cfg_data[pdol_pkg::SKIP_W-1:0];
          pdol_pkg::CFG_DRIVE_START: begin
            drive_r <= {cfg_data[pdol_pkg::DRIVE_W-1:0], {FW{1'b0}}};
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers of the transaction in flight.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end

    unique case (state_r)
      S_EVAL: begin
        mean_r     <= '0;
        offv_r     <= 1'b0;
        off_prod_r <= (pdol_pkg::OFF_PROD_W'(in_r.gps_unix_seconds) + 1'b1)
                      * pdol_pkg::US_PER_S;
        err_r      <= $signed(pdol_pkg::ERR_CALC_W'(period_c))
                      - $signed(pdol_pkg::ERR_CALC_W'(target_r));
        if (in_r.capture_value == pdol_pkg::CAPTURE_SENTINEL) begin
          status_r <= pdol_pkg::ST_SENTINEL;
          period_r <= '0;
        end else if (seen_r < skip_r) begin
          status_r <= pdol_pkg::ST_STARTUP;
          period_r <= '0;
        end else begin
          status_r <= pdol_pkg::ST_OUTLIER;
          period_r <= period_c;
        end
      end
      S_CHECK: begin
        idx_r     <= '0;
        rd_pend_r <= 1'b0;
        sum_r     <= '0;
      end
      S_SUM: begin
        // Read data arrives in the cycle after the address.
        if (rd_issue) begin
          idx_r <= idx_r + 1'b1;
        end
        rd_pend_r <= rd_issue;
        if (rd_pend_r) begin
          sum_r <= sum_r + SUM_W'($signed(win_rdata));
        end
      end
      S_DIVGO: begin
        sum_neg_r <= sum_r[SUM_W-1];
      end
      S_DIV: begin
        if (div_done) begin
          mag_r  <= div_q;
          mean_r <= sum_neg_r ? -pdol_pkg::MEAN_W'(div_q) : pdol_pkg::MEAN_W'(div_q);
        end
      end
      S_MUL: begin
        prod_r <= PROD_W'(mag_r) * PROD_W'(gain_r);
      end
      S_DRV: begin
        status_r <= pdol_pkg::ST_UPDATED;
        offv_r   <= in_r.gps_valid;
      end
      default: ;
    endcase

    if (out_load) begin
      out_r.status          <= status_r;
      out_r.period_count    <= period_r;
      out_r.mean_error_q16  <= mean_r;
      out_r.drive_level     <= drive_r[pdol_pkg::DRIVE_Q_W-1:FW];
      out_r.pps_led         <= led_r;
      out_r.offset_valid    <= offv_r;
      out_r.clock_offset_us <= offset_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // A new result only ever comes out of the final sequencer step.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("out_valid rose outside the final step");

  // The window is summed only after at least one entry has been written.
  a_sum_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (filled_r != '0))
    else $error("window summed while empty");

  // While the window is filling, the write pointer equals the fill count.
  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (filled_r < CNT_W'(WINDOW_DEPTH)) |-> (wslot_r == filled_r[AW-1:0]))
    else $error("write slot and fill count disagree");
`endif

endmodule

// ===== rtl/pdol_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the error window.
module pdol_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pdol_div.sv =====
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Self-contained; computes the window mean for the loop unit.
module pdol_div #(
  parameter int DVD_W = 42,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEPS = (DVD_W + 1) / 2;
  localparam int PAD_W = 2 * STEPS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PAD_W-1:0] dq_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   rem_w;
  logic [DVS_W-1:0] rem_c;
  logic [PAD_W-1:0] dq_c;

  // The dividend shifts out at the top of dq while quotient bits enter at
  // the bottom, so after all steps dq holds the quotient.
  always_comb begin
    rem_c = rem_r;
    dq_c  = dq_r;
    rem_w = '0;
    for (int k = 0; k < 2; k++) begin
      rem_w = {rem_c, dq_c[PAD_W-1]};
      dq_c  = {dq_c[PAD_W-2:0], 1'b0};
      if (rem_w >= {1'b0, dvs_r}) begin
        rem_w   = rem_w - {1'b0, dvs_r};
        dq_c[0] = 1'b1;
      end
      rem_c = rem_w[DVS_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      dq_r  <= dq_c;
      rem_r <= rem_c;
    end else if (start) begin
      dq_r  <= PAD_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r[DVD_W-1:0];

endmodule
